/* rtl/mac_tx_queue_engine_macros.svh */
// Assertion macros shared by the transmit queue RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef MAC_TX_QUEUE_ENGINE_MACROS_SVH
`define MAC_TX_QUEUE_ENGINE_MACROS_SVH

// Same-cycle implication, muted during reset.
`define MTQ_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted during reset.
`define MTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/mtq_pkg.sv */
// Types and codes for the transmit queue: entry layout, cell commands,
// operation and status codes, sequencer states. No dependencies.
`default_nettype none

package mtq_pkg;

   localparam int OCC_W  = 4;
   localparam int ADDR_W = 24;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_GET  = 3'd1;
   localparam logic [2:0] OP_POP  = 3'd2;
   localparam logic [2:0] OP_TAG  = 3'd3;
   localparam logic [2:0] OP_ACKD = 3'd4;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_DUP  = 2'd2;
   localparam logic [1:0] STATUS_NONE = 2'd3;

   typedef struct packed {
      logic [7:0]        tag;
      logic [ADDR_W-1:0] src;
      logic [ADDR_W-1:0] dest;
      logic              is_ack;
      logic [1:0]        ack_mode;
      logic [31:0]       depart;
   } entry_type;

   // Compare keys broadcast to every cell.
   typedef struct packed {
      logic [ADDR_W-1:0] my_addr;
      logic [ADDR_W-1:0] dest;
      logic [7:0]        tag;
      logic [31:0]       now;
   } key_type;

   typedef struct packed {
      logic dup;
      logic due;
      logic tag;
      logic ackd;
   } cell_hit_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_LEFT,
      CELL_FROM_RIGHT
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ACT,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

/* rtl/mtq_cell.sv */
// One queue slot: holds an entry, shifts toward either neighbor or loads
// a new word, and compares its entry against the broadcast keys. Uses mtq_pkg.
`default_nettype none

module mtq_cell (
   input  wire                          clock,
   input  mtq_pkg::cell_cmd_type        cmd,
   input  mtq_pkg::entry_type           load_data,
   input  mtq_pkg::entry_type           from_left,
   input  mtq_pkg::entry_type           from_right,
   input  mtq_pkg::key_type             key,
   output mtq_pkg::entry_type           entry,
   output mtq_pkg::cell_hit_type        hit
);

   mtq_pkg::entry_type entry_ff;
   mtq_pkg::entry_type entry_in;

   always_comb begin
      unique case (cmd)
         mtq_pkg::CELL_HOLD:       entry_in = entry_ff;
         mtq_pkg::CELL_LOAD:       entry_in = load_data;
         mtq_pkg::CELL_FROM_LEFT:  entry_in = from_left;
         mtq_pkg::CELL_FROM_RIGHT: entry_in = from_right;
         default:                  entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry    = entry_ff;
   assign hit.dup  = (entry_ff.src == key.my_addr) && (entry_ff.dest == key.dest);
   assign hit.due  = entry_ff.depart < key.now;
   assign hit.tag  = entry_ff.tag == key.tag;
   assign hit.ackd = (entry_ff.ack_mode != 2'd0) && (entry_ff.dest == key.dest);

endmodule

`default_nettype wire

/* rtl/mac_tx_queue_engine.sv */
// Each request is taken in idle, then passes through scan, act and resp, and the
// response word is registered on leaving resp; remove-acked-destination repeats
// scan and act for each entry removed: each removal is one compare pass over the
// cell row and one shift step. One request at a time: the next is taken once the
// response is registered, and resp waits while an earlier response is unaccepted.
// Reset (synchronous): the queue empties and the local address clears to 0.
`default_nettype none

`include "mac_tx_queue_engine_macros.svh"

module mac_tx_queue_engine #(
   parameter int QUEUE_DEPTH = 8,
   parameter int ACK_RESERVE = 4
) (
   input  wire         clock,
   input  wire         reset,
   // csr_wdata: my_address[23:0]
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [23:0] csr_wdata,
   input  wire         req_tvalid,
   output logic        req_tready,
   // req_tuser: op[2:0]
   input  wire  [2:0]  req_tuser,
   // req_tdata: frame_tag[7:0], src_addr[31:8], dest_addr[55:32], is_ack[56],
   //            ack_mode[58:57], depart_ms[90:59], now_ms[122:91], zero[127:123]
   input  wire  [127:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // rsp_tuser: status[1:0]
   output logic [1:0]  rsp_tuser,
   // rsp_tdata: out_tag[7:0], out_src[31:8], out_dest[55:32], out_is_ack[56],
   //            out_ack_mode[58:57], out_depart[90:59], occupancy[94:91], zero[95]
   output logic [95:0] rsp_tdata
);

   localparam int SLOTS = QUEUE_DEPTH + ACK_RESERVE;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int IDX_W = $clog2(SLOTS);

   mtq_pkg::state_type state_ff, state_in;

   logic [23:0]            my_addr_ff;
   logic [2:0]             op_ff, op_in;
   mtq_pkg::entry_type     new_ff, new_in;
   logic [31:0]            now_ff, now_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SLOTS-1:0]       hit_vec_ff, hit_vec_in;
   logic                   found_ff, found_in;
   logic [1:0]             res_status_ff, res_status_in;
   mtq_pkg::entry_type     res_entry_ff, res_entry_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   mtq_pkg::entry_type     rsp_entry_ff, rsp_entry_in;
   logic [mtq_pkg::OCC_W-1:0] rsp_occ_ff, rsp_occ_in;

   mtq_pkg::key_type       key;
   mtq_pkg::entry_type     ent [SLOTS];
   mtq_pkg::cell_hit_type  hit [SLOTS];
   mtq_pkg::cell_cmd_type  cmd [SLOTS];
   logic [SLOTS-1:0]       live;

   logic [IDX_W-1:0]       first_idx;
   logic                   any_hit;
   logic [CNT_W-1:0]       limit;

   assign key.my_addr = my_addr_ff;
   assign key.dest    = new_ff.dest;
   assign key.tag     = new_ff.tag;
   assign key.now     = now_ff;

   // Cell row: each cell sees its neighbors' entries.
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      mtq_pkg::entry_type left_word, right_word;

      if (g == 0) begin : g_head
         assign left_word = new_ff;
      end else begin : g_mid_l
         assign left_word = ent[g-1];
      end
      if (g == SLOTS - 1) begin : g_tail
         assign right_word = new_ff;
      end else begin : g_mid_r
         assign right_word = ent[g+1];
      end

      assign live[g] = CNT_W'(g) < count_ff;

      mtq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd[g]),
         .load_data  (new_ff),
         .from_left  (left_word),
         .from_right (right_word),
         .key        (key),
         .entry      (ent[g]),
         .hit        (hit[g])
      );
   end

   always_comb begin
      first_idx = '0;
      any_hit   = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (hit_vec_ff[i]) begin
            first_idx = IDX_W'(i);
            any_hit   = 1'b1;
         end
      end
   end

   assign limit = new_ff.is_ack ? CNT_W'(SLOTS) : CNT_W'(QUEUE_DEPTH);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      new_in        = new_ff;
      now_in        = now_ff;
      count_in      = count_ff;
      hit_vec_in    = hit_vec_ff;
      found_in      = found_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_occ_in    = rsp_occ_ff;
      req_tready    = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         cmd[i] = mtq_pkg::CELL_HOLD;
      end

      unique case (state_ff)
         mtq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in           = req_tuser;
               new_in.tag      = req_tdata[7:0];
               new_in.src      = req_tdata[31:8];
               new_in.dest     = req_tdata[55:32];
               new_in.is_ack   = req_tdata[56];
               new_in.ack_mode = req_tdata[58:57];
               new_in.depart   = req_tdata[90:59];
               now_in          = req_tdata[122:91];
               found_in        = 1'b0;
               state_in        = mtq_pkg::ST_SCAN;
            end
         end

         mtq_pkg::ST_SCAN: begin
            // Latch the per-cell match that this op looks for.
            for (int i = 0; i < SLOTS; i++) begin
               unique case (op_ff)
                  mtq_pkg::OP_ADD:  hit_vec_in[i] = live[i] && hit[i].dup;
                  mtq_pkg::OP_GET:  hit_vec_in[i] = live[i] && hit[i].due;
                  mtq_pkg::OP_TAG:  hit_vec_in[i] = live[i] && hit[i].tag;
                  mtq_pkg::OP_ACKD: hit_vec_in[i] = live[i] && hit[i].ackd;
                  default:          hit_vec_in[i] = 1'b0;
               endcase
            end
            state_in = mtq_pkg::ST_ACT;
         end

         mtq_pkg::ST_ACT: begin
            res_entry_in  = '0;
            res_status_in = mtq_pkg::STATUS_NONE;
            state_in      = mtq_pkg::ST_RESP;
            unique case (op_ff)
               mtq_pkg::OP_ADD: begin
                  if (count_ff >= limit) begin
                     res_status_in = mtq_pkg::STATUS_FULL;
                  end else if (new_ff.ack_mode != 2'd0 && any_hit) begin
                     res_status_in = mtq_pkg::STATUS_DUP;
                  end else begin
                     res_status_in = mtq_pkg::STATUS_OK;
                     count_in      = count_ff + CNT_W'(1);
                     for (int i = 0; i < SLOTS; i++) begin
                        if (new_ff.is_ack) begin
                           // ACK goes to the head: push the whole row right.
                           cmd[i] = (i == 0) ? mtq_pkg::CELL_LOAD : mtq_pkg::CELL_FROM_LEFT;
                        end else if (CNT_W'(i) == count_ff) begin
                           cmd[i] = mtq_pkg::CELL_LOAD;
                        end
                     end
                  end
               end
               mtq_pkg::OP_GET: begin
                  if (any_hit) begin
                     res_status_in = mtq_pkg::STATUS_OK;
                     res_entry_in  = ent[first_idx];
                  end
               end
               mtq_pkg::OP_POP: begin
                  if (count_ff != '0) begin
                     res_status_in = mtq_pkg::STATUS_OK;
                     res_entry_in  = ent[0];
                     count_in      = count_ff - CNT_W'(1);
                     for (int i = 0; i < SLOTS; i++) begin
                        cmd[i] = mtq_pkg::CELL_FROM_RIGHT;
                     end
                  end
               end
               mtq_pkg::OP_TAG, mtq_pkg::OP_ACKD: begin
                  if (any_hit) begin
                     count_in = count_ff - CNT_W'(1);
                     for (int i = 0; i < SLOTS; i++) begin
                        if (IDX_W'(i) >= first_idx) begin
                           cmd[i] = mtq_pkg::CELL_FROM_RIGHT;
                        end
                     end
                  end
                  if (op_ff == mtq_pkg::OP_ACKD) begin
                     if (any_hit) begin
                        // Rescan after the shift so no follower is skipped.
                        found_in = 1'b1;
                        state_in = mtq_pkg::ST_SCAN;
                     end else begin
                        res_status_in = found_ff ? mtq_pkg::STATUS_OK : mtq_pkg::STATUS_NONE;
                     end
                  end else if (any_hit) begin
                     res_status_in = mtq_pkg::STATUS_OK;
                  end
               end
               default: begin
                  res_status_in = mtq_pkg::STATUS_NONE;
               end
            endcase
         end

         mtq_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
               rsp_occ_in    = mtq_pkg::OCC_W'(count_ff);
               state_in      = mtq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mtq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         my_addr_ff   <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         if (csr_valid) begin
            my_addr_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      new_ff        <= new_in;
      now_ff        <= now_in;
      hit_vec_ff    <= hit_vec_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_occ_ff, rsp_entry_ff.depart, rsp_entry_ff.ack_mode,
                        rsp_entry_ff.is_ack, rsp_entry_ff.dest, rsp_entry_ff.src,
                        rsp_entry_ff.tag};

   `MTQ_ASSERT(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(SLOTS),
      "queue count overflow")

   `MTQ_ASSERT_NEXT(a_full_hold, clock, reset,
      state_ff == mtq_pkg::ST_ACT && op_ff == mtq_pkg::OP_ADD && !new_ff.is_ack
         && count_ff >= CNT_W'(QUEUE_DEPTH),
      $stable(count_ff), "ordinary frame took a reserve slot")

   `MTQ_ASSERT_NEXT(a_pop_dec, clock, reset,
      state_ff == mtq_pkg::ST_ACT && op_ff == mtq_pkg::OP_POP && count_ff != '0,
      count_ff == $past(count_ff) - CNT_W'(1), "pop did not drop one entry")

   `MTQ_ASSERT_NEXT(a_rsp_load, clock, reset,
      state_ff == mtq_pkg::ST_RESP && (!rsp_valid_ff || rsp_tready),
      rsp_valid_ff && state_ff == mtq_pkg::ST_IDLE, "response word not loaded")

endmodule

`default_nettype wire
